@@ design/gww_pkg.sv @@
package gww_pkg;

    localparam int CW           = 6;
    localparam int DATA_W       = 8;
    localparam int MAX_COLS_DEF = 32;

    localparam logic [CW-1:0]     MAX_COLS_RST = CW'(32);
    localparam logic [DATA_W-1:0] CH_NL        = 8'h0A;
    localparam logic [DATA_W-1:0] CH_CR        = 8'h0D;
    localparam logic [DATA_W-1:0] CH_SP        = 8'h20;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] out_char;
        logic              line_break;
        logic              end_of_text;
        logic              last;
    } out_item_t;

endpackage

@@ design/gww_ram.sv @@
module gww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/greedy_word_wrap_stream_core.sv @@
// Channel   | Ports                     | Moves
// ----------+---------------------------+--------------------------------------
// input     | s_valid, s_ready, s_data  | one text byte or end-of-text request
// result    | m_valid, m_ready, m_data  | one character or line break
// config    | cfg_wr_en, cfg_wr_data    | max_cols, written without wait
//
// One request at a time. A byte that only joins the word passes the byte and add
// states (a carriage return only the byte state, one after a held one an extra add
// state first); a space, newline or end of text with no word ends in the tail state.
// A word flush runs pre, chars and post states, bound by the single RAM read port.
// Reset is synchronous; the word buffer needs no clearing pass after reset.
// With m_ready low the sequencer stalls once the output and hold registers are full.
module greedy_word_wrap_stream_core
    import gww_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [CW-1:0] cfg_wr_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_item_t      s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output out_item_t     m_data
);

    localparam int WLW = $clog2(MAX_COLS + 1);
    localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_BYTE    = 4'd1;
    localparam logic [3:0] S_ADD     = 4'd2;
    localparam logic [3:0] S_ENDWORD = 4'd3;
    localparam logic [3:0] S_PRE     = 4'd4;
    localparam logic [3:0] S_CHARS   = 4'd5;
    localparam logic [3:0] S_POST    = 4'd6;
    localparam logic [3:0] S_TAIL    = 4'd7;
    localparam logic [3:0] S_FINAL   = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    localparam logic [1:0] CONT_DONE  = 2'd0;
    localparam logic [1:0] CONT_BYTE  = 2'd1;
    localparam logic [1:0] CONT_FINAL = 2'd2;

    localparam logic [1:0] PRE_NONE = 2'd0;
    localparam logic [1:0] PRE_SP   = 2'd1;
    localparam logic [1:0] PRE_BRK  = 2'd2;

    function automatic logic [3:0] cont_state(input logic [1:0] c);
        logic [3:0] s;
        unique case (c)
            CONT_BYTE:  s = S_BYTE;
            CONT_FINAL: s = S_FINAL;
            default:    s = S_DONE;
        endcase
        return s;
    endfunction

    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    max_cols_reg;
    logic [WLW-1:0]   wl_reg, wl_next;
    logic [WLW-1:0]   ll_reg, ll_next;
    logic             ilw_reg, ilw_next;
    logic             crp_reg, crp_next;
    logic [1:0]       cont_reg, cont_next;
    logic [1:0]       pre_reg, pre_next;
    logic             post_reg, post_next;
    logic             wpend_reg, wpend_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [WLW-1:0]   idx_reg, idx_next;
    logic [WLW-1:0]   nch_reg, nch_next;
    logic             hold_valid_reg, hold_valid_next;
    out_item_t        hold_reg, hold_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;
    logic             mode_reg, mode_next;
    logic [DATA_W-1:0] byte_reg, byte_next;
    logic [DATA_W-1:0] ch_reg, ch_next;

    logic [CW-1:0]    cols;
    logic [CW-1:0]    wl_ext, ll_ext;
    logic [CW:0]      fit_sum;
    logic [WLW-1:0]   idx_inc;
    logic             out_free, emit_ok, emit_fire;
    out_item_t        emit_item;
    logic             ram_we, ram_re;
    logic [DATA_W-1:0] ram_rdata;

    always_comb begin
        cols = max_cols_reg;
        if (max_cols_reg == '0) begin
            cols = CW'(1);
        end else if (max_cols_reg > CW'(MAX_COLS)) begin
            cols = CW'(MAX_COLS);
        end
    end

    assign wl_ext   = CW'(wl_reg);
    assign ll_ext   = CW'(ll_reg);
    assign fit_sum  = (CW + 1)'(ll_ext) + (CW + 1)'(wl_ext) + (CW + 1)'(1);
    assign idx_inc  = idx_reg + 1'b1;
    assign out_free = !m_valid_reg || m_ready;
    assign emit_ok  = !hold_valid_reg || out_free;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        wl_next         = wl_reg;
        ll_next         = ll_reg;
        ilw_next        = ilw_reg;
        crp_next        = crp_reg;
        cont_next       = cont_reg;
        pre_next        = pre_reg;
        post_next       = post_reg;
        wpend_next      = wpend_reg;
        rd_pend_next    = rd_pend_reg;
        idx_next        = idx_reg;
        nch_next        = nch_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        m_data_next     = m_data_reg;
        mode_next       = mode_reg;
        byte_next       = byte_reg;
        ch_next         = ch_reg;
        emit_fire       = 1'b0;
        emit_item       = '0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next = s_data.mode;
                    byte_next = s_data.in_byte;
                    if (s_data.mode || s_data.in_byte == CH_NL) begin
                        crp_next   = 1'b0;
                        cont_next  = CONT_FINAL;
                        state_next = S_ENDWORD;
                    end else if (crp_reg) begin
                        crp_next   = 1'b0;
                        ch_next    = CH_CR;
                        cont_next  = CONT_BYTE;
                        state_next = S_ADD;
                    end else begin
                        state_next = S_BYTE;
                    end
                end
            end
            S_BYTE: begin
                cont_next = CONT_DONE;
                if (byte_reg == CH_CR) begin
                    crp_next   = 1'b1;
                    state_next = S_DONE;
                end else if (byte_reg == CH_SP) begin
                    state_next = S_ENDWORD;
                end else begin
                    ch_next    = byte_reg;
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                if (wl_ext >= cols) begin
                    pre_next     = (!ilw_reg && ll_reg != '0) ? PRE_BRK : PRE_NONE;
                    post_next    = 1'b1;
                    nch_next     = wl_reg;
                    idx_next     = '0;
                    rd_pend_next = 1'b0;
                    wl_next      = '0;
                    ll_next      = '0;
                    ilw_next     = 1'b1;
                    wpend_next   = 1'b1;
                    state_next   = S_PRE;
                end else begin
                    ram_we     = 1'b1;
                    wl_next    = wl_reg + 1'b1;
                    state_next = cont_state(cont_reg);
                end
            end
            S_ENDWORD: begin
                wpend_next   = 1'b0;
                idx_next     = '0;
                rd_pend_next = 1'b0;
                nch_next     = wl_reg;
                if (ilw_reg) begin
                    ilw_next = 1'b0;
                    if (wl_reg != '0) begin
                        pre_next   = PRE_NONE;
                        post_next  = 1'b1;
                        wl_next    = '0;
                        ll_next    = '0;
                        state_next = S_PRE;
                    end else begin
                        state_next = S_TAIL;
                    end
                end else if (wl_reg == '0) begin
                    state_next = S_TAIL;
                end else if (wl_ext > cols) begin
                    pre_next   = (ll_reg != '0) ? PRE_BRK : PRE_NONE;
                    post_next  = 1'b1;
                    wl_next    = '0;
                    ll_next    = '0;
                    state_next = S_PRE;
                end else begin
                    post_next  = 1'b0;
                    wl_next    = '0;
                    state_next = S_PRE;
                    if (ll_reg == '0) begin
                        pre_next = PRE_NONE;
                        ll_next  = wl_reg;
                    end else if (fit_sum <= (CW + 1)'(cols)) begin
                        pre_next = PRE_SP;
                        ll_next  = WLW'(fit_sum);
                    end else begin
                        pre_next = PRE_BRK;
                        ll_next  = wl_reg;
                    end
                end
            end
            S_PRE: begin
                if (pre_reg == PRE_NONE) begin
                    state_next = S_CHARS;
                end else if (emit_ok) begin
                    emit_fire = 1'b1;
                    if (pre_reg == PRE_SP) begin
                        emit_item.out_char = CH_SP;
                    end else begin
                        emit_item.line_break = 1'b1;
                    end
                    state_next = S_CHARS;
                end
            end
            S_CHARS: begin
                if (idx_reg == nch_reg) begin
                    state_next = S_POST;
                end else if (!rd_pend_reg) begin
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                end else if (emit_ok) begin
                    emit_fire          = 1'b1;
                    emit_item.out_char = ram_rdata;
                    idx_next           = idx_inc;
                    if (idx_inc != nch_reg) begin
                        ram_re = 1'b1;
                    end else begin
                        rd_pend_next = 1'b0;
                    end
                end
            end
            S_POST: begin
                if (!post_reg) begin
                    state_next = S_TAIL;
                end else if (emit_ok) begin
                    emit_fire            = 1'b1;
                    emit_item.line_break = 1'b1;
                    state_next           = S_TAIL;
                end
            end
            S_TAIL: begin
                if (wpend_reg) begin
                    ram_we     = 1'b1;
                    wl_next    = wl_reg + 1'b1;
                    wpend_next = 1'b0;
                end
                state_next = cont_state(cont_reg);
            end
            S_FINAL: begin
                if (emit_ok) begin
                    emit_fire             = 1'b1;
                    emit_item.line_break  = 1'b1;
                    emit_item.end_of_text = mode_reg;
                    ll_next               = '0;
                    state_next            = S_DONE;
                end
            end
            S_DONE: begin
                if (!hold_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = hold_reg;
                    m_data_next.last = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emit_fire) begin
            if (hold_valid_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = hold_reg;
            end
            hold_next       = emit_item;
            hold_valid_next = 1'b1;
        end
    end

    gww_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_COLS)
    ) u_word_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wl_reg[AW-1:0]),
        .wdata (ch_reg),
        .re    (ram_re),
        .raddr (ram_re && rd_pend_reg ? idx_inc[AW-1:0] : idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            max_cols_reg   <= MAX_COLS_RST;
            wl_reg         <= '0;
            ll_reg         <= '0;
            ilw_reg        <= 1'b0;
            crp_reg        <= 1'b0;
            cont_reg       <= CONT_DONE;
            pre_reg        <= PRE_NONE;
            post_reg       <= 1'b0;
            wpend_reg      <= 1'b0;
            rd_pend_reg    <= 1'b0;
            idx_reg        <= '0;
            nch_reg        <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_wr_en) begin
                max_cols_reg <= cfg_wr_data;
            end
            wl_reg         <= wl_next;
            ll_reg         <= ll_next;
            ilw_reg        <= ilw_next;
            crp_reg        <= crp_next;
            cont_reg       <= cont_next;
            pre_reg        <= pre_next;
            post_reg       <= post_next;
            wpend_reg      <= wpend_next;
            rd_pend_reg    <= rd_pend_next;
            idx_reg        <= idx_next;
            nch_reg        <= nch_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg   <= hold_next;
        m_data_reg <= m_data_next;
        mode_reg   <= mode_next;
        byte_reg   <= byte_next;
        ch_reg     <= ch_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
